// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl file that carries checks
// depends on clk and arst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define RCPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent that holds in the clock after its antecedent
`define RCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rcpf_pkg.sv -----
// shared types, constants and helper functions of the rc packet framer
// no dependencies
`default_nettype none

package rcpf_pkg;

	localparam int CHANNEL_LIMIT = 10000;
	localparam int STICK_SPAN    = 500;
	localparam int STICK_CENTER  = 1500;
	localparam int QUANT_HALF    = CHANNEL_LIMIT / 2;

	localparam int IN_W      = 16;
	localparam int MAG_W     = 15;
	localparam int PROD_W    = 24;
	localparam int QUOT_W    = 9;
	localparam int SCALED_W  = 11;
	localparam int QLEVEL_W  = 2;

	// reciprocal of the limit for the scaling divide
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 25;
	localparam longint unsigned RECIP_VAL = (64'd1 << RECIP_SHIFT) / CHANNEL_LIMIT;

	localparam int NUM_STICKS = 5;
	localparam int LANE_T = 0;
	localparam int LANE_A = 1;
	localparam int LANE_E = 2;
	localparam int LANE_R = 3;
	localparam int LANE_X = 4;

	localparam int ID_W      = 32;
	localparam int CHAN_W    = 7;
	localparam int HOP_MOD   = 37;
	localparam int HOP_BASE  = 2;
	localparam int HOP_STEP  = 40;
	localparam int BIND_CHANNEL = 1;

	// weights of the id bytes modulo the hop modulus
	localparam int FOLD_W1 = 256 % HOP_MOD;
	localparam int FOLD_W2 = 65536 % HOP_MOD;
	localparam int FOLD_W3 = 16777216 % HOP_MOD;
	localparam int FOLD_W  = 15;
	localparam int FOLD_SHIFT = 16;
	localparam int FOLD_RECIP = 65536 / HOP_MOD;

	localparam int PAYLOAD_LEN = 15;
	localparam int IDX_W       = 4;
	localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PAYLOAD_LEN - 1);

	localparam logic [7:0] RX_ADDR0 = 8'h73;
	localparam logic [7:0] RX_ADDR1 = 8'h73;
	localparam logic [7:0] RX_ADDR2 = 8'h74;
	localparam logic [7:0] RX_ADDR3 = 8'h63;

	localparam logic [15:0] MASK_NIBBLE = 16'h00F0;
	localparam logic [15:0] MASK_MODE   = 16'h00C0;
	localparam logic [15:0] MASK_AUX    = 16'h0030;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                                bind_frame;
		logic [NUM_STICKS-1:0][IN_W-1:0]     stick;
		logic [IN_W-1:0]                     mode_sw;
		logic [IN_W-1:0]                     aux_seven;
	} req_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} stick_mag_t;

	typedef struct packed {
		logic                          bind_frame;
		logic [CHAN_W-1:0]             chan;
		logic [PAYLOAD_LEN-1:0][7:0]   data;
	} frame_t;

	function automatic stick_mag_t clamp_mag(input logic signed [IN_W-1:0] v);
		stick_mag_t r;
		int         vi;
		vi = int'(v);
		if (vi > CHANNEL_LIMIT) begin
			r.neg = 1'b0;
			r.mag = MAG_W'(CHANNEL_LIMIT);
		end else if (vi < -CHANNEL_LIMIT) begin
			r.neg = 1'b1;
			r.mag = MAG_W'(CHANNEL_LIMIT);
		end else if (vi < 0) begin
			r.neg = 1'b1;
			r.mag = MAG_W'(-vi);
		end else begin
			r.neg = 1'b0;
			r.mag = MAG_W'(vi);
		end
		return r;
	endfunction

	function automatic logic [QLEVEL_W-1:0] quantize2(input logic signed [IN_W-1:0] v);
		logic [QLEVEL_W-1:0] q;
		int                  vi;
		vi = int'(v);
		if (vi >= 0)
			q = (vi >= QUANT_HALF) ? 2'd3 : 2'd2;
		else
			q = (vi < -QUANT_HALF) ? 2'd0 : 2'd1;
		return q;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rc_control_packet_framer.sv -----
// top level of the rc control packet framer: front end, frame queue, serializer
// depends on rcpf_pkg, rcpf_front, rcpf_queue, rcpf_back and assert_macros.svh
//
// channel     direction  handshake                        payload
// config      in         cfg_valid / cfg_ready            cfg_data (transmitter id)
// request     in         push / full                      bind_frame, seven stick channels
// result      out        empty / pop                      payload_byte, byte_index,
//                                                         radio_channel, last_byte
//
// each request yields fifteen byte transactions, one per cycle from the serializer
// while pop keeps up and the queue holds a frame; the serializer sets the stream rate
// the first byte passes the three front stages, the queue and the result register
// after the request transaction, the first stage loaded at the accepting edge
// reset clears pipeline valids, queue pointers, hop select and the id register
// a stalled result side fills the two-entry queue, then the front pipeline holds
// and full rises; no clearing pass
`default_nettype none
`include "assert_macros.svh"

module rc_control_packet_framer import rcpf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [ID_W-1:0]        cfg_data,
	// request side
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   bind_frame,
	input  wire logic signed [IN_W-1:0] throttle_in,
	input  wire logic signed [IN_W-1:0] aileron_in,
	input  wire logic signed [IN_W-1:0] elevator_in,
	input  wire logic signed [IN_W-1:0] rudder_in,
	input  wire logic signed [IN_W-1:0] mode_switch_in,
	input  wire logic signed [IN_W-1:0] aux_six_in,
	input  wire logic signed [IN_W-1:0] aux_seven_in,
	// result side
	output logic                        empty,
	input  wire logic                   pop,
	output logic [7:0]                  payload_byte,
	output logic [IDX_W-1:0]            byte_index,
	output logic [CHAN_W-1:0]           radio_channel,
	output logic                        last_byte
);

	req_t   req;
	frame_t fr_entry;
	frame_t head;
	logic   fr_push;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;

	// helpers for the checks at the end
	logic             at_final;
	logic             mid_pop;
	logic [IDX_W-1:0] nxt_idx;
	logic             chan_in_band;

	// id register always takes a write
	assign cfg_ready = 1'b1;

	// pack the request transaction for the front end
	always_comb begin
		req.bind_frame     = bind_frame;
		req.stick[LANE_T]  = throttle_in;
		req.stick[LANE_A]  = aileron_in;
		req.stick[LANE_E]  = elevator_in;
		req.stick[LANE_R]  = rudder_in;
		req.stick[LANE_X]  = aux_six_in;
		req.mode_sw        = mode_switch_in;
		req.aux_seven      = aux_seven_in;
	end

	// clamp, scale and quantize, hop selection, frame bytes
	rcpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.req      (req),
		.q_push   (fr_push),
		.q_entry  (fr_entry),
		.q_full   (q_full)
	);

	// decouples frame building from byte streaming
	rcpf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fr_push),
		.wr_data (fr_entry),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_data (head),
		.q_empty (q_empty)
	);

	// one byte per cycle into the result register while pop keeps up, checksum on the fly
	rcpf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.payload_byte  (payload_byte),
		.byte_index    (byte_index),
		.radio_channel (radio_channel),
		.last_byte     (last_byte)
	);

	assign at_final     = (byte_index == LAST_INDEX);
	assign mid_pop      = pop && !empty && !last_byte;
	assign nxt_idx      = IDX_W'(byte_index + 1'b1);
	assign chan_in_band = (radio_channel >= CHAN_W'(BIND_CHANNEL))
		&& (radio_channel <= CHAN_W'(HOP_MOD - 1 + HOP_BASE + HOP_STEP));

	// last marker sits on the final index only
	`RCPF_ASSERT(a_last_on_final, !empty |-> (last_byte == at_final), "last marker off final byte")

	// inside a frame the next byte follows at once with the next index
	`RCPF_ASSERT_NEXT(a_index_step, mid_pop, !empty && byte_index == $past(nxt_idx), "index skip")

	// channel holds across a frame
	`RCPF_ASSERT_NEXT(a_chan_hold, mid_pop, radio_channel == $past(radio_channel), "channel moved")

	// channel stays in the legal band
	`RCPF_ASSERT(a_chan_range, !empty |-> chan_in_band, "radio channel out of band")

endmodule

`default_nettype wire

// ----- rtl/rcpf_front.sv -----
// front end: id register, hop pair, stick scaling pipeline and frame assembly
// depends on rcpf_pkg; feeds rcpf_queue
`default_nettype none

module rcpf_front import rcpf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [ID_W-1:0] cfg_data,
	input  wire logic            push,
	output logic                 full,
	input  wire req_t            req,
	output logic                 q_push,
	output frame_t               q_entry,
	input  wire logic            q_full
);

	logic [ID_W-1:0]   id_q;
	logic [FOLD_W-1:0] fold_q;
	logic [CHAN_W-1:0] hop0_q;
	logic              hop_sel_q;

	logic adv;

	logic                                 v_s1, v_s2, v_s3;
	logic                                 bind_s1, bind_s2, bind_s3;
	logic [QLEVEL_W-1:0]                  m_s1, m_s2, m_s3;
	logic [QLEVEL_W-1:0]                  s_s1, s_s2, s_s3;
	logic [NUM_STICKS-1:0]                neg_s1, neg_s2;
	logic [NUM_STICKS-1:0][PROD_W-1:0]    prod_s1, prod_s2;
	logic [NUM_STICKS-1:0][QUOT_W-1:0]    est_s2;
	logic [NUM_STICKS-1:0][SCALED_W-1:0]  val_s3;

	logic [NUM_STICKS-1:0][PROD_W-1:0]    prod_d;
	logic [NUM_STICKS-1:0]                neg_d;
	logic [NUM_STICKS-1:0][QUOT_W-1:0]    est_d;
	logic [NUM_STICKS-1:0][SCALED_W-1:0]  val_d;

	logic [FOLD_W-1:0] fold_d;
	logic [CHAN_W-1:0] hop0_d;
	logic [CHAN_W-1:0] hop1;

	// whole pipeline holds while the last stage cannot enter the queue
	assign adv    = !(v_s3 && q_full);
	assign full   = !adv;
	assign q_push = v_s3 && !q_full;

	// hop pair from the id: fold bytes by their residues, then one reduction
	always_comb begin
		logic [FOLD_W+FOLD_SHIFT-1:0] wide;
		logic [FOLD_W-1:0]            est;
		logic [FOLD_W-1:0]            rem;
		fold_d = FOLD_W'(int'(id_q[7:0]) + FOLD_W1 * int'(id_q[15:8])
			+ FOLD_W2 * int'(id_q[23:16]) + FOLD_W3 * int'(id_q[31:24]));
		wide   = (FOLD_W+FOLD_SHIFT)'(fold_q) * (FOLD_W+FOLD_SHIFT)'(FOLD_RECIP);
		est    = FOLD_W'(wide >> FOLD_SHIFT);
		rem    = FOLD_W'(int'(fold_q) - int'(est) * HOP_MOD);
		if (rem >= FOLD_W'(HOP_MOD))
			rem = FOLD_W'(int'(rem) - HOP_MOD);
		hop0_d = CHAN_W'(int'(rem) + HOP_BASE);
	end

	assign hop1 = CHAN_W'(int'(hop0_q) + HOP_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q      <= '0;
			fold_q    <= '0;
			hop0_q    <= CHAN_W'(HOP_BASE);
			hop_sel_q <= 1'b0;
		end else begin
			if (cfg_we)
				id_q <= cfg_data;
			fold_q <= fold_d;
			hop0_q <= hop0_d;
			if (q_push && !bind_s3)
				hop_sel_q <= !hop_sel_q;
		end
	end

	// per lane: clamp and times span, reciprocal estimate, correction, offset from the centre
	always_comb begin
		stick_mag_t cm;
		logic [PROD_W+RECIP_W-1:0] wide;
		logic [PROD_W-1:0]         rem;
		logic [QUOT_W-1:0]         quo;
		for (int i = 0; i < NUM_STICKS; i++) begin
			cm        = clamp_mag(req.stick[i]);
			neg_d[i]  = cm.neg;
			prod_d[i] = PROD_W'(int'(cm.mag) * STICK_SPAN);
			wide      = (PROD_W+RECIP_W)'(prod_s1[i]) * (PROD_W+RECIP_W)'(RECIP_VAL);
			est_d[i]  = QUOT_W'(wide >> RECIP_SHIFT);
			rem       = prod_s2[i] - PROD_W'(int'(est_s2[i]) * CHANNEL_LIMIT);
			quo       = (rem >= PROD_W'(CHANNEL_LIMIT)) ? QUOT_W'(est_s2[i] + 1'b1) : est_s2[i];
			val_d[i]  = neg_s2[i] ? SCALED_W'(STICK_CENTER - int'(quo))
				: SCALED_W'(STICK_CENTER + int'(quo));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bind_s1 <= req.bind_frame;
			m_s1    <= quantize2(req.mode_sw);
			s_s1    <= quantize2(req.aux_seven);
			neg_s1  <= neg_d;
			prod_s1 <= prod_d;
			bind_s2 <= bind_s1;
			m_s2    <= m_s1;
			s_s2    <= s_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= prod_s1;
			est_s2  <= est_d;
			bind_s3 <= bind_s2;
			m_s3    <= m_s2;
			s_s3    <= s_s2;
			val_s3  <= val_d;
		end
	end

	// payload assembly
	always_comb begin
		logic [15:0] t, a, e, r, x, m, s;
		t = 16'(val_s3[LANE_T]);
		a = 16'(val_s3[LANE_A]);
		e = 16'(val_s3[LANE_E]);
		r = 16'(val_s3[LANE_R]);
		x = 16'(val_s3[LANE_X]);
		m = 16'(m_s3);
		s = 16'(s_s3);
		q_entry.bind_frame = bind_s3;
		q_entry.data       = '0;
		if (bind_s3) begin
			q_entry.chan     = CHAN_W'(BIND_CHANNEL);
			q_entry.data[0]  = id_q[31:24];
			q_entry.data[1]  = id_q[23:16];
			q_entry.data[2]  = id_q[15:8];
			q_entry.data[3]  = id_q[7:0];
			q_entry.data[4]  = RX_ADDR0;
			q_entry.data[5]  = RX_ADDR1;
			q_entry.data[6]  = RX_ADDR2;
			q_entry.data[7]  = RX_ADDR3;
			q_entry.data[8]  = id_q[31:24];
			q_entry.data[9]  = id_q[23:16];
			q_entry.data[10] = id_q[15:8];
			q_entry.data[11] = id_q[7:0];
		end else begin
			q_entry.chan    = hop_sel_q ? hop1 : hop0_q;
			q_entry.data[0] = 8'(hop0_q);
			q_entry.data[1] = 8'(hop1);
			q_entry.data[2] = 8'(((m << 6) & MASK_MODE) | ((s << 4) & MASK_AUX) | (t >> 8));
			q_entry.data[3] = t[7:0];
			q_entry.data[4] = 8'(((x >> 4) & MASK_NIBBLE) | (a >> 8));
			q_entry.data[5] = a[7:0];
			q_entry.data[6] = 8'((x & MASK_NIBBLE) | (e >> 8));
			q_entry.data[7] = e[7:0];
			q_entry.data[8] = 8'(((x << 4) & MASK_NIBBLE) | (r >> 8));
			q_entry.data[9] = r[7:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rcpf_queue.sv -----
// short frame queue between the front end and the byte serializer
// depends on rcpf_pkg
`default_nettype none

module rcpf_queue import rcpf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr,
	input  wire frame_t wr_data,
	output logic        q_full,
	input  wire logic   rd,
	output frame_t      rd_data,
	output logic        q_empty
);

	frame_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign q_full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wptr_q + 1'b1);
			if (do_rd)
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rptr_q + 1'b1);
			if (do_wr && !do_rd)
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			else if (do_rd && !do_wr)
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rcpf_back.sv -----
// back end: walks the queue head byte by byte into the result register
// depends on rcpf_pkg; reads rcpf_queue
`default_nettype none

module rcpf_back import rcpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire frame_t      head,
	input  wire logic        q_empty,
	output logic             q_pop,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       payload_byte,
	output logic [IDX_W-1:0] byte_index,
	output logic [CHAN_W-1:0] radio_channel,
	output logic             last_byte
);

	logic              out_valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        sum_q;
	logic [7:0]        byte_q;
	logic [IDX_W-1:0]  index_q;
	logic [CHAN_W-1:0] chan_q;
	logic              last_q;
	logic              load;
	logic              at_last;
	logic [7:0]        cur_byte;

	assign load    = !q_empty && (!out_valid_q || pop);
	assign at_last = (idx_q == LAST_INDEX);
	assign q_pop   = load && at_last;

	// checksum only on control frames
	assign cur_byte = at_last ? (head.bind_frame ? 8'h00 : sum_q) : head.data[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			sum_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? '0 : IDX_W'(idx_q + 1'b1);
				sum_q       <= at_last ? '0 : 8'(sum_q + cur_byte);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= cur_byte;
			index_q <= idx_q;
			chan_q  <= head.chan;
			last_q  <= at_last;
		end
	end

	assign empty         = !out_valid_q;
	assign payload_byte  = byte_q;
	assign byte_index    = index_q;
	assign radio_channel = chan_q;
	assign last_byte     = last_q;

endmodule

`default_nettype wire
